FILE: hdl/text_window_scroll_engine_defines.svh
// Assertion macros used by the checker file.
`ifndef TEXT_WINDOW_SCROLL_ENGINE_DEFINES_SVH
`define TEXT_WINDOW_SCROLL_ENGINE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TWSE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TWSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/twse_pkg.sv
package twse_pkg;

  localparam int ColW    = 7;
  localparam int RowW    = 5;
  localparam int CellW   = 16;
  localparam int DefCols = 80;
  localparam int DefRows = 25;

  localparam logic [7:0] BlankChar = 8'h20;

  typedef enum logic [2:0] {
    OP_PUT     = 3'd0,
    OP_SETCOL  = 3'd1,
    OP_SETROW  = 3'd2,
    OP_SETBOTH = 3'd3,
    OP_RECT    = 3'd4,
    OP_READ    = 3'd5
  } op_e;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_RDCELL = 5'b00100,
    S_WALK   = 5'b01000,
    S_COPYWR = 5'b10000
  } state_e;

  // Clipped rectangle and scroll amount handed to the walker.
  typedef struct packed {
    logic [ColW-1:0] x1;
    logic [ColW-1:0] x2;
    logic [RowW-1:0] y1;
    logic [RowW-1:0] y2;
    logic [RowW:0]   n;
    logic            down;
  } rect_t;

  // Current cell of the walk.
  typedef struct packed {
    logic [RowW-1:0] dst_row;
    logic [RowW-1:0] src_row;
    logic [ColW-1:0] col;
    logic            copy;
    logic            last;
  } walk_t;

endpackage

FILE: hdl/twse_if.sv
interface twse_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        opcode;
  logic [7:0]        char_code;
  logic [7:0]        attribute;
  logic [6:0]        col_a;
  logic [4:0]        row_a;
  logic [6:0]        col_b;
  logic [4:0]        row_b;
  logic signed [7:0] shift_rows;

  modport source (
    output valid, opcode, char_code, attribute, col_a, row_a, col_b, row_b, shift_rows,
    input  ready
  );
  modport sink (
    input  valid, opcode, char_code, attribute, col_a, row_a, col_b, row_b, shift_rows,
    output ready
  );
endinterface

interface twse_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] cell_value;
  logic [6:0]  cursor_col;
  logic [4:0]  cursor_row;

  modport source (
    output valid, cell_value, cursor_col, cursor_row,
    input  ready
  );
  modport sink (
    input  valid, cell_value, cursor_col, cursor_row,
    output ready
  );
endinterface

FILE: hdl/twse_ram.sv
module twse_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/twse_walk.sv
module twse_walk (
  input  logic            clk_i,
  input  logic            start_i,
  input  twse_pkg::rect_t rect_i,
  input  logic            step_i,
  output twse_pkg::walk_t walk_o
);
  import twse_pkg::*;

  rect_t           rect_q;
  logic [RowW-1:0] row_q;
  logic [ColW-1:0] col_q;
  logic [RowW+1:0] sum_up;
  logic [RowW+1:0] lim_dn;
  logic            copy;
  logic            row_end;
  logic [RowW-1:0] last_row;

  // Scrolling up walks top to bottom, scrolling down bottom to top, so a source
  // row is always read before it is overwritten.
  assign sum_up   = (RowW+2)'(row_q) + (RowW+2)'(rect_q.n);
  assign lim_dn   = (RowW+2)'(rect_q.y1) + (RowW+2)'(rect_q.n);
  assign copy     = rect_q.down ? ((RowW+2)'(row_q) >= lim_dn)
                                : (sum_up <= (RowW+2)'(rect_q.y2));
  assign row_end  = (col_q == rect_q.x2);
  assign last_row = rect_q.down ? rect_q.y1 : rect_q.y2;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rect_q <= rect_i;
      row_q  <= rect_i.down ? rect_i.y2 : rect_i.y1;
      col_q  <= rect_i.x1;
    end else if (step_i) begin
      if (row_end) begin
        col_q <= rect_q.x1;
        row_q <= rect_q.down ? row_q - RowW'(1) : row_q + RowW'(1);
      end else begin
        col_q <= col_q + ColW'(1);
      end
    end
  end

  always_comb begin
    walk_o.dst_row = row_q;
    walk_o.src_row = rect_q.down ? row_q - rect_q.n[RowW-1:0] : sum_up[RowW-1:0];
    walk_o.col     = col_q;
    walk_o.copy    = copy;
    walk_o.last    = row_end && (row_q == last_row);
  end

endmodule

FILE: hdl/text_window_scroll_engine.sv
// Text-mode cell store with cursor. For put char, cursor moves and unused opcodes the
// result is registered as the item is taken, and so it is for a clear or scroll whose
// rectangle is empty after clipping. A read cell passes through the S_RDCELL state
// because the cell memory has a registered read port. A clear or scroll walks the
// clipped rectangle one cell at a time after the cycle that takes the item: a filled
// cell is written with the fill value, and a moved cell is read, then written back
// through the same memory. After reset the block zeroes the memory, one cell a cycle,
// before it takes the first item. A finished result waits in an output register, and
// the next item is taken no earlier than the cycle in which that result leaves.
module text_window_scroll_engine #(
  parameter int COLS = twse_pkg::DefCols,
  parameter int ROWS = twse_pkg::DefRows
) (
  input logic       clk_i,
  input logic       rst_ni,
  twse_in_if.sink   in_i,
  twse_out_if.source out_o
);
  import twse_pkg::*;

  localparam int Depth = ROWS * COLS;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [ColW:0]   ColsL  = (ColW+1)'(COLS);
  localparam logic [RowW+1:0] RowsL  = (RowW+2)'(ROWS);
  localparam logic [ColW-1:0] ColMax = ColW'(COLS - 1);
  localparam logic [RowW:0]   RowMax = (RowW+1)'(ROWS - 1);

  state_e           state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [ColW-1:0]  cur_col_q, cur_col_d;
  logic [RowW-1:0]  cur_row_q, cur_row_d;
  logic             out_valid_q, out_valid_d;
  logic [CellW-1:0] out_cell_q, out_cell_d;
  logic [ColW-1:0]  out_col_q, out_col_d;
  logic [RowW-1:0]  out_row_q, out_row_d;
  logic             rd_ok_q, rd_ok_d;
  logic [CellW-1:0] fill_q, fill_d;

  logic             in_ready;
  logic             accept;
  logic             cur_in_win;
  logic             rd_in_win;
  logic [ColW-1:0]  x2s;
  logic [RowW:0]    y2s_w;
  logic [RowW-1:0]  y2s;
  logic             rect_empty;
  logic [RowW:0]    height;
  logic [7:0]       mag;
  rect_t            rect_cfg;
  walk_t            walk;
  logic             walk_start;
  logic             walk_step;
  logic             finish;

  logic             we;
  logic             re;
  logic [AddrW-1:0] waddr;
  logic [AddrW-1:0] raddr;
  logic [CellW-1:0] wdata;
  logic [CellW-1:0] rdata;

  function automatic logic [AddrW-1:0] cell_addr(logic [RowW-1:0] r, logic [ColW-1:0] c);
    return AddrW'(AddrW'(r) * AddrW'(COLS)) + AddrW'(c);
  endfunction

  assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);
  assign accept   = in_i.valid && in_ready;

  assign cur_in_win = ({1'b0, cur_col_q} < ColsL) && ({2'b00, cur_row_q} < RowsL);
  assign rd_in_win  = ({1'b0, in_i.col_a} < ColsL) && ({2'b00, in_i.row_a} < RowsL);

  // Clip the rectangle and saturate the scroll amount at its height; an amount of zero also takes the full height.
  assign x2s        = (in_i.col_b > ColMax) ? ColMax : in_i.col_b;
  assign y2s_w      = ({1'b0, in_i.row_b} > RowMax) ? RowMax : {1'b0, in_i.row_b};
  assign y2s        = y2s_w[RowW-1:0];
  assign rect_empty = (in_i.col_a > x2s) || (in_i.row_a > y2s);
  assign height     = (RowW+1)'(y2s) - (RowW+1)'(in_i.row_a) + (RowW+1)'(1);
  assign mag        = in_i.shift_rows[7] ? (8'd0 - in_i.shift_rows) : in_i.shift_rows;

  always_comb begin
    rect_cfg.x1   = in_i.col_a;
    rect_cfg.x2   = x2s;
    rect_cfg.y1   = in_i.row_a;
    rect_cfg.y2   = y2s;
    rect_cfg.down = in_i.shift_rows[7];
    if ((mag == 8'd0) || (mag > 8'(height))) begin
      rect_cfg.n = height;
    end else begin
      rect_cfg.n = mag[RowW:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_cell_d  = out_cell_q;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    rd_ok_d     = rd_ok_q;
    fill_d      = fill_q;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = cell_addr(walk.dst_row, walk.col);
    raddr       = cell_addr(walk.src_row, walk.col);
    wdata       = fill_q;
    walk_start  = 1'b0;
    walk_step   = 1'b0;
    finish      = 1'b0;

    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + AddrW'(1);
        if (clr_q == AddrW'(Depth - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (in_i.opcode)
            OP_PUT: begin
              if (cur_in_win) begin
                we    = 1'b1;
                waddr = cell_addr(cur_row_q, cur_col_q);
                wdata = {in_i.attribute, in_i.char_code};
              end
            end
            OP_SETCOL: begin
              cur_col_d = in_i.col_a;
            end
            OP_SETROW: begin
              cur_row_d = in_i.row_a;
            end
            OP_SETBOTH: begin
              cur_col_d = in_i.col_a;
              cur_row_d = in_i.row_a;
            end
            OP_RECT: begin
              if (!rect_empty) begin
                walk_start = 1'b1;
                fill_d     = {in_i.attribute, BlankChar};
                state_d    = S_WALK;
              end
            end
            OP_READ: begin
              re      = 1'b1;
              raddr   = cell_addr(in_i.row_a, in_i.col_a);
              rd_ok_d = rd_in_win;
              state_d = S_RDCELL;
            end
            default: begin
            end
          endcase
          if (state_d == S_IDLE) begin
            out_valid_d = 1'b1;
            out_cell_d  = '0;
            out_col_d   = cur_col_d;
            out_row_d   = cur_row_d;
          end
        end
      end
      S_RDCELL: begin
        out_valid_d = 1'b1;
        out_cell_d  = rd_ok_q ? rdata : '0;
        out_col_d   = cur_col_q;
        out_row_d   = cur_row_q;
        state_d     = S_IDLE;
      end
      S_WALK: begin
        if (walk.copy) begin
          re      = 1'b1;
          state_d = S_COPYWR;
        end else begin
          we        = 1'b1;
          walk_step = 1'b1;
          finish    = walk.last;
        end
      end
      S_COPYWR: begin
        we        = 1'b1;
        wdata     = rdata;
        walk_step = 1'b1;
        finish    = walk.last;
        state_d   = S_WALK;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (finish) begin
      out_valid_d = 1'b1;
      out_cell_d  = '0;
      out_col_d   = cur_col_q;
      out_row_d   = cur_row_q;
      state_d     = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_cell_q <= out_cell_d;
    out_col_q  <= out_col_d;
    out_row_q  <= out_row_d;
    rd_ok_q    <= rd_ok_d;
    fill_q     <= fill_d;
  end

  twse_walk u_walk (
    .clk_i   (clk_i),
    .start_i (walk_start),
    .rect_i  (rect_cfg),
    .step_i  (walk_step),
    .walk_o  (walk)
  );

  twse_ram #(
    .WIDTH (CellW),
    .DEPTH (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.cell_value = out_cell_q;
  assign out_o.cursor_col = out_col_q;
  assign out_o.cursor_row = out_row_q;

endmodule

FILE: hdl/twse_checker.sv
`include "text_window_scroll_engine_defines.svh"

module twse_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [2:0] in_opcode_i,
  input logic [6:0] in_col_a_i,
  input logic [4:0] in_row_a_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [15:0] out_cell_i,
  input logic [6:0] out_col_i,
  input logic [4:0] out_row_i
);
  import twse_pkg::*;

  logic in_acc;
  logic out_stall;

  assign in_acc    = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  `TWSE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i && $stable(out_cell_i) && $stable(out_col_i) && $stable(out_row_i), "Stalled result changed.")
  `TWSE_ASSERT_SAME(a_no_overrun, clk_i, rst_ni, in_acc, !out_stall, "Item taken while the result slot is blocked.")
  `TWSE_ASSERT_NEXT(a_setcol, clk_i, rst_ni, in_acc && (in_opcode_i == OP_SETCOL), out_valid_i && (out_col_i == $past(in_col_a_i)) && (out_cell_i == 16'd0), "Set column result is wrong.")
  `TWSE_ASSERT_NEXT(a_setboth, clk_i, rst_ni, in_acc && (in_opcode_i == OP_SETBOTH), out_valid_i && (out_col_i == $past(in_col_a_i)) && (out_row_i == $past(in_row_a_i)), "Set cursor result is wrong.")

endmodule

bind text_window_scroll_engine twse_checker u_twse_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_opcode_i (in_i.opcode),
  .in_col_a_i  (in_i.col_a),
  .in_row_a_i  (in_i.row_a),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_cell_i  (out_o.cell_value),
  .out_col_i   (out_o.cursor_col),
  .out_row_i   (out_o.cursor_row)
);
